// ----- design/css_token_scanner_defines.svh -----
// Assertion macros used by the style-sheet token scanner checker.
`ifndef CSS_TOKEN_SCANNER_DEFINES_SVH
`define CSS_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cts_pkg.sv -----
// Shared types and constants of the style-sheet token scanner.
package cts_pkg;

    localparam int POS_BITS_DEFAULT = 16;

    // Most tokens that one input byte can produce, and the queue between the halves.
    localparam int TOK_MAX     = 4;
    localparam int TOK_IDX_W   = $clog2(TOK_MAX);
    localparam int TOK_CNT_W   = $clog2(TOK_MAX + 1);
    localparam int QUEUE_DEPTH = 4;

    localparam int          TDATA_W   = 64;
    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    localparam logic [3:0] KIND_END    = 4'd0;
    localparam logic [3:0] KIND_LBRACE = 4'd1;
    localparam logic [3:0] KIND_RBRACE = 4'd2;
    localparam logic [3:0] KIND_COLON  = 4'd3;
    localparam logic [3:0] KIND_SEMI   = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_DOT    = 4'd6;
    localparam logic [3:0] KIND_HASH   = 4'd7;
    localparam logic [3:0] KIND_IDENT  = 4'd8;
    localparam logic [3:0] KIND_COLOUR = 4'd9;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [23:0] rgb;
        logic        endm;
    } t_tok;

    // All tokens caused by one input byte, in output order.
    typedef struct packed {
        logic [TOK_CNT_W-1:0]     cnt;
        t_tok [TOK_MAX-1:0]       toks;
    } t_bundle;

endpackage

// ----- design/cts_front.sv -----
// Front half: accepts text bytes, runs the scanner state and builds token bundles.
module cts_front #(
    parameter int POSITION_BITS = cts_pkg::POS_BITS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_q_ready,
    output logic              o_ready,
    output logic              o_push,
    output cts_pkg::t_bundle  o_bundle
);

    localparam int P  = POSITION_BITS;
    localparam int SW = (P > 16) ? P : 16;
    localparam logic [P-1:0] POS_MAX = {P{1'b1}};

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_SLASH   = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_CSTAR   = 3'd3;
    localparam logic [2:0] M_IDENT   = 3'd4;
    localparam logic [2:0] M_HASH    = 3'd5;
    localparam logic [2:0] M_DONE    = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        cts_pkg::t_tok tok;
        logic          to_ident;
    } t_close;

    function automatic logic [15:0] sat16(input logic [P-1:0] v);
        logic [SW-1:0] ext;
        ext = SW'(v);
        return (ext > SW'(cts_pkg::FIELD_MAX)) ? cts_pkg::FIELD_MAX : ext[15:0];
    endfunction

    function automatic cts_pkg::t_tok mk_tok(input logic [3:0] kind, input logic [P-1:0] start,
                                             input logic [P-1:0] len, input logic [23:0] rgb,
                                             input logic endm);
        cts_pkg::t_tok t;
        t.kind  = kind;
        t.start = sat16(start);
        t.len   = sat16(len);
        t.rgb   = rgb;
        t.endm  = endm;
        return t;
    endfunction

    // {valid, letter, nibble}
    function automatic logic [5:0] hex_info(input logic [7:0] c);
        logic [5:0] r;
        r = '0;
        if (c inside {[CH_0:CH_9]}) begin
            r = {2'b10, c[3:0]};
        end else if (c inside {[CH_LA:CH_LF]}) begin
            r = {2'b11, 4'(c - CH_LA) + 4'd10};
        end else if (c inside {[CH_UA:CH_UF]}) begin
            r = {2'b11, 4'(c - CH_UA) + 4'd10};
        end
        return r;
    endfunction

    function automatic logic starts_name(input logic [7:0] c);
        return (c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_US, CH_DASH});
    endfunction

    function automatic logic in_name(input logic [7:0] c);
        return starts_name(c) || (c inside {[CH_0:CH_9]});
    endfunction

    // Ends the hex run after a hash: a colour for exactly three or six digits, else a bare hash.
    function automatic t_close close_hash(input logic [2:0] hc, input logic [23:0] acc,
                                          input logic hs, input logic [P-1:0] ps,
                                          input logic [P-1:0] pos);
        t_close     r;
        logic [23:0] rgb;
        r   = '0;
        // Scaling a nibble by 17 repeats it in both halves of the byte.
        rgb = {acc[11:8], acc[11:8], acc[7:4], acc[7:4], acc[3:0], acc[3:0]};
        if (hc == 3'd3 || hc == 3'd6) begin
            r.tok = mk_tok(cts_pkg::KIND_COLOUR, ps, pos - ps, (hc == 3'd3) ? rgb : acc, 1'b0);
        end else begin
            r.tok      = mk_tok(cts_pkg::KIND_HASH, ps, P'(1), '0, 1'b0);
            r.to_ident = hs;
        end
        return r;
    endfunction

    logic [2:0]   r_mode, n_mode;
    logic [P-1:0] r_pos, n_pos;
    logic [P-1:0] r_ps, n_ps;
    logic [2:0]   r_hc, n_hc;
    logic [P-1:0] r_hp, n_hp;
    logic         r_hs, n_hs;
    logic [23:0]  r_acc, n_acc;

    logic                               c_accept;
    logic [5:0]                         c_hex;
    logic                               c_used;
    t_close                             c_close;
    logic [P-1:0]                       c_end_at;
    logic [cts_pkg::TOK_CNT_W-1:0]      c_cnt;
    cts_pkg::t_tok [cts_pkg::TOK_MAX-1:0] c_toks;

    assign c_accept = i_valid && i_q_ready;
    assign c_hex    = hex_info(i_byte);
    assign o_ready  = i_q_ready;
    assign o_push   = c_accept && (c_cnt != '0);
    assign o_bundle.cnt  = c_cnt;
    assign o_bundle.toks = c_toks;

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_ps     = r_ps;
        n_hc     = r_hc;
        n_hp     = r_hp;
        n_hs     = r_hs;
        n_acc    = r_acc;
        c_used   = 1'b0;
        c_close  = '0;
        c_end_at = '0;
        c_cnt    = '0;
        c_toks   = '0;

        if (r_mode != M_DONE) begin
            if (i_byte == CH_NUL) begin
                if (n_mode == M_HASH) begin
                    c_close = close_hash(n_hc, n_acc, n_hs, n_ps, n_pos);
                    c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] = c_close.tok;
                    c_cnt = c_cnt + 1'b1;
                    if (c_close.to_ident) begin
                        n_mode = M_IDENT;
                        n_ps   = n_hp;
                    end else begin
                        n_mode = M_IDLE;
                    end
                end
                if (n_mode == M_IDENT) begin
                    c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] =
                        mk_tok(cts_pkg::KIND_IDENT, n_ps, n_pos - n_ps, '0, 1'b0);
                    c_cnt = c_cnt + 1'b1;
                end
                n_mode = M_DONE;
                n_ps   = n_pos;
            end else begin
                if (n_mode == M_HASH) begin
                    if (c_hex[5]) begin
                        if (n_hc < 3'd6) begin
                            n_acc = {n_acc[19:0], c_hex[3:0]};
                        end
                        if (n_hc != 3'd7) begin
                            n_hc = n_hc + 3'd1;
                        end
                        if (c_hex[4] && !n_hs) begin
                            n_hs = 1'b1;
                            n_hp = n_pos;
                        end
                        c_used = 1'b1;
                    end else begin
                        c_close = close_hash(n_hc, n_acc, n_hs, n_ps, n_pos);
                        c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] = c_close.tok;
                        c_cnt = c_cnt + 1'b1;
                        if (c_close.to_ident) begin
                            n_mode = M_IDENT;
                            n_ps   = n_hp;
                        end else begin
                            n_mode = M_IDLE;
                        end
                    end
                end
                if (!c_used && n_mode == M_IDENT) begin
                    if (in_name(i_byte)) begin
                        c_used = 1'b1;
                    end else begin
                        c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] =
                            mk_tok(cts_pkg::KIND_IDENT, n_ps, n_pos - n_ps, '0, 1'b0);
                        c_cnt  = c_cnt + 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                if (!c_used && n_mode == M_SLASH) begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_COMMENT;
                        c_used = 1'b1;
                    end else begin
                        n_mode = M_IDLE;
                    end
                end
                if (!c_used && n_mode == M_COMMENT) begin
                    if (i_byte == CH_STAR) begin
                        n_mode = M_CSTAR;
                    end
                    c_used = 1'b1;
                end
                if (!c_used && n_mode == M_CSTAR) begin
                    if (i_byte == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else if (i_byte != CH_STAR) begin
                        n_mode = M_COMMENT;
                    end
                    c_used = 1'b1;
                end
                if (!c_used) begin
                    case (i_byte)
                        CH_LBRACE, CH_RBRACE, CH_COLON, CH_SEMI, CH_COMMA, CH_DOT: begin
                            c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] = mk_tok(
                                (i_byte == CH_LBRACE) ? cts_pkg::KIND_LBRACE :
                                (i_byte == CH_RBRACE) ? cts_pkg::KIND_RBRACE :
                                (i_byte == CH_COLON)  ? cts_pkg::KIND_COLON  :
                                (i_byte == CH_SEMI)   ? cts_pkg::KIND_SEMI   :
                                (i_byte == CH_COMMA)  ? cts_pkg::KIND_COMMA  :
                                                        cts_pkg::KIND_DOT,
                                n_pos, P'(1), '0, 1'b0);
                            c_cnt = c_cnt + 1'b1;
                        end
                        CH_SLASH: begin
                            n_mode = M_SLASH;
                        end
                        CH_HASH: begin
                            n_mode = M_HASH;
                            n_ps   = n_pos;
                            n_hc   = '0;
                            n_hs   = 1'b0;
                            n_hp   = '0;
                            n_acc  = '0;
                        end
                        default: begin
                            if (starts_name(i_byte)) begin
                                n_mode = M_IDENT;
                                n_ps   = n_pos;
                            end
                        end
                    endcase
                end
                if (n_pos != POS_MAX) begin
                    n_pos = n_pos + P'(1);
                end
            end
        end

        if (i_last) begin
            if (n_mode == M_DONE) begin
                c_end_at = n_ps;
            end else begin
                if (n_mode == M_HASH) begin
                    c_close = close_hash(n_hc, n_acc, n_hs, n_ps, n_pos);
                    c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] = c_close.tok;
                    c_cnt = c_cnt + 1'b1;
                    if (c_close.to_ident) begin
                        n_mode = M_IDENT;
                        n_ps   = n_hp;
                    end else begin
                        n_mode = M_IDLE;
                    end
                end
                if (n_mode == M_IDENT) begin
                    c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] =
                        mk_tok(cts_pkg::KIND_IDENT, n_ps, n_pos - n_ps, '0, 1'b0);
                    c_cnt = c_cnt + 1'b1;
                end
                c_end_at = n_pos;
            end
            c_toks[c_cnt[cts_pkg::TOK_IDX_W-1:0]] =
                mk_tok(cts_pkg::KIND_END, c_end_at, '0, '0, 1'b1);
            c_cnt  = c_cnt + 1'b1;
            // The stream is over: start the next one from the reset state.
            n_mode = M_IDLE;
            n_pos  = '0;
            n_ps   = '0;
            n_hc   = '0;
            n_hp   = '0;
            n_hs   = 1'b0;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pos  <= '0;
            r_ps   <= '0;
            r_hc   <= '0;
            r_hp   <= '0;
            r_hs   <= 1'b0;
            r_acc  <= '0;
        end else if (c_accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_ps   <= n_ps;
            r_hc   <= n_hc;
            r_hp   <= n_hp;
            r_hs   <= n_hs;
            r_acc  <= n_acc;
        end
    end

endmodule

// ----- design/cts_queue.sv -----
// Short queue of token bundles between the scanner front and the output back.
module cts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cts_pkg::t_bundle i_bundle,
    output logic             o_ready,
    output logic             o_valid,
    output cts_pkg::t_bundle o_head,
    input  logic             i_pop
);

    localparam int DEPTH = cts_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cts_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

// ----- design/cts_back.sv -----
// Back half: walks the head bundle, one token per unstalled cycle, into the output register.
module cts_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  cts_pkg::t_bundle             i_head,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [cts_pkg::TDATA_W-1:0]  o_tdata,
    output logic                         o_tlast
);

    logic [cts_pkg::TOK_IDX_W-1:0] r_idx;
    logic                          r_tvalid;
    cts_pkg::t_tok                 r_tok;
    logic                          c_load;
    logic                          c_final;

    assign c_load  = i_valid && (!r_tvalid || i_tready);
    assign c_final = (cts_pkg::TOK_CNT_W'(r_idx) + 1'b1) == i_head.cnt;
    assign o_pop   = c_load && c_final;

    assign o_tvalid = r_tvalid;
    assign o_tlast  = r_tok.endm;
    assign o_tdata  = cts_pkg::TDATA_W'({r_tok.rgb, r_tok.len, r_tok.start, r_tok.kind});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (c_load) begin
                r_tvalid <= 1'b1;
                r_idx    <= c_final ? '0 : r_idx + 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_tok <= i_head.toks[r_idx];
        end
    end

endmodule

// ----- design/css_token_scanner.sv -----
// Style-sheet token scanner: one text byte per cycle in, tokens with offset, length and colour out.
// The block takes one byte per cycle while its four-entry queue of per-byte token bundles has
// room; every byte, even one that yields no token, waits while that queue is full. Each byte
// yields zero to four tokens (kind, start offset, length, decoded colour, end flag), and the
// output register sends one token per cycle while the sink is ready, so a byte that yields
// several tokens holds back the bytes behind it once the queue has filled. A byte's bundle is
// written into the queue when the byte is accepted, and its first token is then loaded into
// the output register once that register is free. tlast on the input marks the final byte; the
// block then flushes any pending token, sends an end token with tlast high and starts afresh.
module css_token_scanner #(
    parameter int POSITION_BITS = cts_pkg::POS_BITS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,   // [7:0] text_byte
    input  logic                        i_s_axis_tlast,   // final_byte
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [3:0] token_kind, [19:4] token_start, [35:20] token_length, [59:36] color_rgb, rest zero
    output logic [cts_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic                        o_m_axis_tlast    // end_marker
);

    logic             q_ready;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    cts_pkg::t_bundle q_in;
    cts_pkg::t_bundle q_head;

    cts_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_q_ready (q_ready),
        .o_ready   (o_s_axis_tready),
        .o_push    (q_push),
        .o_bundle  (q_in)
    );

    cts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_in),
        .o_ready  (q_ready),
        .o_valid  (q_valid),
        .o_head   (q_head),
        .i_pop    (q_pop)
    );

    cts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule

// ----- design/cts_checker.sv -----
// Port-level checks of the style-sheet token scanner, bound to its top level.
`include "css_token_scanner_defines.svh"

module cts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [7:0]                  i_s_axis_tdata,
    input logic                        i_s_axis_tlast,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [cts_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tlast
);

    // The end token carries no length and no colour.
    `CTS_ASSERT_NOW(a_end_form, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata[3:0] == cts_pkg::KIND_END && o_m_axis_tdata[35:20] == 16'd0 && o_m_axis_tdata[59:36] == 24'd0, "end token malformed")

    // Every other token has a real kind other than end.
    `CTS_ASSERT_NOW(a_token_form, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, o_m_axis_tdata[3:0] != cts_pkg::KIND_END && o_m_axis_tdata[3:0] <= cts_pkg::KIND_COLOUR, "token kind out of place")

    // A full queue means the output register has long been loaded.
    `CTS_ASSERT_NOW(a_full_has_out, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with nothing on the output")

    // A stalled request keeps its token.
    `CTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output token changed")

endmodule

bind css_token_scanner cts_checker u_cts_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the style-sheet token scanner stream block.
`timescale 1ns / 1ps

module tb_top;

    localparam int          CYCLE_LIMIT = 400_000;
    localparam int          IDLE_PCT    = 19;
    localparam logic [15:0] POS_TOP     = 16'hFFFF;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_CSTAR,
        SCAN_NAME,
        SCAN_HASH,
        SCAN_OVER
    } t_scan_state;

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = 8'd0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [cts_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;

    css_token_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    string NAME_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_-0123456789";
    string HEX_CHARS  = "0123456789abcdefABCDEF";
    string PUNCT      = "{}:;,.";
    string FILLER     = " \t\n\r~!@?";

    // Scanner state as the predictor sees it.
    t_scan_state scan_st;
    logic [15:0] byte_pos;
    logic [15:0] tok_start;
    logic [15:0] letter_pos;
    logic [2:0]  hex_cnt;
    logic        letter_seen;
    logic [23:0] nibbles;
    int          step_tokens;

    cts_pkg::t_tok tokens_due[$];
    logic [7:0]    pending_text[$];
    int            fault_count = 0;
    int            cycle_count = 0;
    int            hold_cycles = 0;
    bit            steady      = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Token sink: random stalls unless steady, and a long hold-off when a test wants one.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic void clear_scanner();
        scan_st     = SCAN_IDLE;
        byte_pos    = '0;
        tok_start   = '0;
        letter_pos  = '0;
        hex_cnt     = '0;
        letter_seen = 1'b0;
        nibbles     = '0;
    endfunction

    function automatic bit name_head(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b == "-";
    endfunction

    function automatic void push_token(logic [3:0] kind, logic [15:0] at, logic [15:0] len,
                                       logic [23:0] rgb, logic endm);
        if (step_tokens < cts_pkg::TOK_MAX) begin
            tokens_due.push_back(cts_pkg::t_tok'{kind, at, len, rgb, endm});
            step_tokens++;
        end
    endfunction

    // The hex run after a hash has ended at offset at.
    function automatic void close_hash(logic [15:0] at);
        logic [23:0] rgb;
        if (hex_cnt == 3'd3 || hex_cnt == 3'd6) begin
            // Repeating a nibble in both halves of a byte multiplies it by 17.
            rgb = (hex_cnt == 3'd3) ? {nibbles[11:8], nibbles[11:8], nibbles[7:4],
                                       nibbles[7:4], nibbles[3:0], nibbles[3:0]} : nibbles;
            push_token(cts_pkg::KIND_COLOUR, tok_start, at - tok_start, rgb, 1'b0);
            scan_st = SCAN_IDLE;
        end else begin
            push_token(cts_pkg::KIND_HASH, tok_start, 16'd1, 24'd0, 1'b0);
            if (letter_seen) begin
                scan_st   = SCAN_NAME;
                tok_start = letter_pos;
            end else begin
                scan_st = SCAN_IDLE;
            end
        end
    endfunction

    function automatic void flush_pending(logic [15:0] at);
        if (scan_st == SCAN_HASH) close_hash(at);
        if (scan_st == SCAN_NAME) begin
            push_token(cts_pkg::KIND_IDENT, tok_start, at - tok_start, 24'd0, 1'b0);
        end
        scan_st = SCAN_IDLE;
    endfunction

    // Works out every token that one accepted byte causes.
    function automatic void scan_byte(logic [7:0] b, logic fin);
        int          nib;
        bit          taken;
        logic [15:0] end_at;
        step_tokens = 0;
        if (scan_st != SCAN_OVER) begin
            if (b == 8'd0) begin
                flush_pending(byte_pos);
                scan_st   = SCAN_OVER;
                tok_start = byte_pos;
            end else begin
                taken = 1'b0;
                if (scan_st == SCAN_HASH) begin
                    if (b >= "0" && b <= "9") nib = b - "0";
                    else if (b >= "a" && b <= "f") nib = b - "a" + 10;
                    else if (b >= "A" && b <= "F") nib = b - "A" + 10;
                    else nib = -1;
                    if (nib >= 0) begin
                        if (hex_cnt < 3'd6) nibbles = {nibbles[19:0], nib[3:0]};
                        if (hex_cnt < 3'd7) hex_cnt++;
                        if (nib >= 10 && !letter_seen) begin
                            letter_seen = 1'b1;
                            letter_pos  = byte_pos;
                        end
                        taken = 1'b1;
                    end else begin
                        close_hash(byte_pos);
                    end
                end
                if (!taken && scan_st == SCAN_NAME) begin
                    if (name_head(b) || (b >= "0" && b <= "9")) begin
                        taken = 1'b1;
                    end else begin
                        push_token(cts_pkg::KIND_IDENT, tok_start, byte_pos - tok_start, 24'd0,
                                   1'b0);
                        scan_st = SCAN_IDLE;
                    end
                end
                if (!taken && scan_st == SCAN_SLASH) begin
                    if (b == "*") begin
                        scan_st = SCAN_COMMENT;
                        taken   = 1'b1;
                    end else begin
                        scan_st = SCAN_IDLE;
                    end
                end
                if (!taken && scan_st == SCAN_COMMENT) begin
                    if (b == "*") scan_st = SCAN_CSTAR;
                    taken = 1'b1;
                end
                if (!taken && scan_st == SCAN_CSTAR) begin
                    if (b == "/") scan_st = SCAN_IDLE;
                    else if (b != "*") scan_st = SCAN_COMMENT;
                    taken = 1'b1;
                end
                if (!taken) begin
                    case (b)
                        "{": push_token(cts_pkg::KIND_LBRACE, byte_pos, 16'd1, 24'd0, 1'b0);
                        "}": push_token(cts_pkg::KIND_RBRACE, byte_pos, 16'd1, 24'd0, 1'b0);
                        ":": push_token(cts_pkg::KIND_COLON, byte_pos, 16'd1, 24'd0, 1'b0);
                        ";": push_token(cts_pkg::KIND_SEMI, byte_pos, 16'd1, 24'd0, 1'b0);
                        ",": push_token(cts_pkg::KIND_COMMA, byte_pos, 16'd1, 24'd0, 1'b0);
                        ".": push_token(cts_pkg::KIND_DOT, byte_pos, 16'd1, 24'd0, 1'b0);
                        "/": scan_st = SCAN_SLASH;
                        "#": begin
                            scan_st     = SCAN_HASH;
                            tok_start   = byte_pos;
                            hex_cnt     = '0;
                            letter_seen = 1'b0;
                            letter_pos  = '0;
                            nibbles     = '0;
                        end
                        default: begin
                            if (name_head(b)) begin
                                scan_st   = SCAN_NAME;
                                tok_start = byte_pos;
                            end
                        end
                    endcase
                end
                if (byte_pos != POS_TOP) byte_pos++;
            end
        end
        if (fin) begin
            if (scan_st == SCAN_OVER) begin
                end_at = tok_start;
            end else begin
                flush_pending(byte_pos);
                end_at = byte_pos;
            end
            push_token(cts_pkg::KIND_END, end_at, 16'd0, 24'd0, 1'b1);
            clear_scanner();
        end
    endfunction

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        cts_pkg::t_tok want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (tokens_due.size() == 0) begin
                $error("token with none expected: kind %0d start %0d", m_tdata[3:0],
                       m_tdata[19:4]);
                fault_count++;
            end else begin
                want = tokens_due.pop_front();
                check_field("token_kind", want.kind, m_tdata[3:0]);
                check_field("token_start", want.start, m_tdata[19:4]);
                check_field("token_length", want.len, m_tdata[35:20]);
                check_field("color_rgb", want.rgb, m_tdata[59:36]);
                check_field("padding", 24'd0, m_tdata[63:60]);
                check_field("end_marker", want.endm, m_tlast);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge i_clk); while (!s_tready);
        scan_byte(b, fin);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
    endtask

    // Sends the collected text as one stream, the last byte flagged as final.
    task automatic send_stream();
        for (int i = 0; i < pending_text.size(); i++) begin
            send_byte(pending_text[i], i == pending_text.size() - 1);
        end
        pending_text.delete();
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_punctuation_and_names();
        add_text("{}:;,.");
        pending_text.push_back(8'hFF);
        add_text("-Z9");
        send_stream();
    endtask

    // Three and six digit colours with hex letters, and a run too long to be a colour.
    task automatic test_hash_and_colours();
        add_text("#fFf#0A1b2C#2a5 #1234567");
        send_stream();
        add_text("#abc");
        send_stream();
    endtask

    task automatic test_comments_and_slash();
        add_text("a/b/*x**/c/*");
        send_stream();
    endtask

    task automatic test_zero_byte();
        add_text("ab");
        pending_text.push_back(8'd0);
        add_text("{x");
        send_stream();
    endtask

    task automatic test_output_backpressure();
        steady      = 1'b1;
        hold_cycles = 80;
        repeat (24) pending_text.push_back(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
        send_stream();
        pause_until_drained();
        steady = 1'b0;
    endtask

    task automatic test_random_streams();
        int token_bytes;
        int stream_no;
        int n;
        token_bytes = 0;
        stream_no   = 0;
        while (token_bytes < 30) begin
            steady = (stream_no == 1);
            repeat ($urandom_range(2, 8)) begin
                case ($urandom_range(0, 10))
                    0, 1: begin
                        n = $urandom_range(1, 6);
                        pending_text.push_back(NAME_CHARS[$urandom_range(0, 53)]);
                        repeat (n - 1) pending_text.push_back(NAME_CHARS[$urandom_range(0, 63)]);
                        token_bytes += n;
                    end
                    2, 3: begin
                        n = $urandom_range(0, 1) ? 6 : 3;
                        pending_text.push_back("#");
                        repeat (n) pending_text.push_back(HEX_CHARS[$urandom_range(0, 21)]);
                        token_bytes += n + 1;
                    end
                    4: begin
                        n = $urandom_range(0, 9);
                        pending_text.push_back("#");
                        repeat (n) pending_text.push_back(HEX_CHARS[$urandom_range(0, 21)]);
                        token_bytes += n + 1;
                    end
                    5: begin
                        pending_text.push_back(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
                        token_bytes++;
                    end
                    6: begin
                        repeat ($urandom_range(1, 3)) begin
                            pending_text.push_back(FILLER[$urandom_range(0, FILLER.len() - 1)]);
                        end
                    end
                    7: begin
                        add_text("/*");
                        repeat ($urandom_range(0, 4)) pending_text.push_back($urandom_range(1, 255));
                        add_text($urandom_range(0, 1) ? "*/" : "**/");
                    end
                    8: begin
                        pending_text.push_back($urandom_range(1, 255));
                        token_bytes++;
                    end
                    9: begin
                        pending_text.push_back("/");
                        pending_text.push_back($urandom_range(1, 255));
                        token_bytes += 2;
                    end
                    default: begin
                        // Sometimes the text ends early; bytes after the zero are ignored.
                        if ($urandom_range(0, 2) == 0) begin
                            pending_text.push_back(8'd0);
                            repeat ($urandom_range(1, 3)) begin
                                pending_text.push_back($urandom_range(0, 255));
                            end
                        end
                    end
                endcase
            end
            if (pending_text.size() == 0 || $urandom_range(0, 1) == 0) begin
                pending_text.push_back($urandom_range(0, 255));
            end
            send_stream();
            stream_no++;
        end
        steady = 1'b0;
    endtask

    initial begin
        clear_scanner();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_punctuation_and_names();
        test_hash_and_colours();
        test_comments_and_slash();
        test_zero_byte();
        test_output_backpressure();
        test_random_streams();
        pause_until_drained();
        repeat (16) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/cts_pkg.sv
design/cts_front.sv
design/cts_queue.sv
design/cts_back.sv
design/css_token_scanner.sv
design/cts_checker.sv
verif/tb_top.sv
